@@ hdl/dpr_pkg.sv @@
// shared types, constants and status codes of the doppler pitch ratio unit
package dpr_pkg;

    localparam int SQRT_STEPS = 22;
    localparam int DIV_STEPS  = 32;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_DISABLED   = 3'd1;
    localparam logic [2:0] ST_COINCIDENT = 3'd2;
    localparam logic [2:0] ST_ZERO_DEN   = 3'd3;
    localparam logic [2:0] ST_SATURATED  = 3'd4;

    localparam logic [1:0] REG_ENABLE        = 2'd0;
    localparam logic [1:0] REG_SOUND_SPEED   = 2'd1;
    localparam logic [1:0] REG_VELOCITY_GAIN = 2'd2;

    localparam logic        RST_ENABLE        = 1'b1;
    localparam logic [31:0] RST_SOUND_SPEED   = 32'd22478848;
    localparam logic [23:0] RST_VELOCITY_GAIN = 24'd65536;
    localparam logic [31:0] RATIO_ONE         = 32'd65536;

    // token moving through the square root cells
    typedef struct packed {
        logic               vld;
        logic [2:0]         st;
        logic [43:0]        rad;
        logic [23:0]        rem;
        logic [21:0]        root;
        logic signed [55:0] dot_s;
        logic signed [55:0] dot_l;
    } t_sqrt_tok;

    // token moving through the divider cells
    typedef struct packed {
        logic        vld;
        logic [2:0]  st;
        logic        neg;
        logic [63:0] rem;
        logic [63:0] ad;
        logic [31:0] lo;
        logic [31:0] q;
    } t_div_tok;

endpackage

@@ hdl/dpr_sqrt_cell.sv @@
// one root digit step of the integer square root chain
module dpr_sqrt_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  dpr_pkg::t_sqrt_tok i_tok,
    output dpr_pkg::t_sqrt_tok o_tok
);
    import dpr_pkg::*;

    t_sqrt_tok   r_tok;
    t_sqrt_tok   n_tok;
    logic [25:0] w_cur;
    logic [25:0] w_trial;

    always_comb begin
        w_cur   = {i_tok.rem, i_tok.rad[43:42]};
        w_trial = {2'b00, i_tok.root, 2'b01};
        n_tok   = i_tok;
        n_tok.rad = {i_tok.rad[41:0], 2'b00};
        if (w_cur >= w_trial) begin
            n_tok.rem  = 24'(w_cur - w_trial);
            n_tok.root = {i_tok.root[20:0], 1'b1};
        end else begin
            n_tok.rem  = w_cur[23:0];
            n_tok.root = {i_tok.root[20:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;
endmodule

@@ hdl/dpr_div_cell.sv @@
// one quotient bit step of the restoring divider chain
module dpr_div_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  dpr_pkg::t_div_tok i_tok,
    output dpr_pkg::t_div_tok o_tok
);
    import dpr_pkg::*;

    t_div_tok    r_tok;
    t_div_tok    n_tok;
    logic [64:0] w_cur;
    logic [64:0] w_dvs;

    always_comb begin
        w_cur    = {i_tok.rem, i_tok.lo[31]};
        w_dvs    = {1'b0, i_tok.ad};
        n_tok    = i_tok;
        n_tok.lo = {i_tok.lo[30:0], 1'b0};
        if (w_cur >= w_dvs) begin
            n_tok.rem = 64'(w_cur - w_dvs);
            n_tok.q   = {i_tok.q[30:0], 1'b1};
        end else begin
            n_tok.rem = w_cur[63:0];
            n_tok.q   = {i_tok.q[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;
endmodule

@@ hdl/doppler_pitch_ratio_unit.sv @@
// top level of the doppler pitch ratio unit: front end, cell chains and output
// usage
//   input channel: i_valid with o_stall, one request holds source and listener
//   position and velocity (signed Q16.16); taken when i_valid and !o_stall
//   output channel: o_valid with i_stall, one result per request, pitch ratio
//   in signed Q16.16 and a status code, taken when o_valid and !i_stall
//   throughput: one request per cycle while no held result stalls the pipeline,
//   every stage is a register and the root and divide are chains of cells that each do one digit per cycle
//   path from acceptance to o_valid: 6 front stages, 22 root cells,
//   5 middle stages, 32 divider cells, one output register
//   stall: when the output register holds a result and i_stall is high the
//   whole pipeline freezes and o_stall rises in that same cycle; no result
//   is lost or repeated
//   reset: synchronous, active low, empties the pipeline and loads the
//   register defaults (enabled, speed of sound 343.0, gain 1.0)
//   configuration: apb port, enable at 0x0, sound_speed at 0x4,
//   velocity_gain at 0x8; write only while no request is in flight
module doppler_pitch_ratio_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_src_pos_x,
    input  logic signed [31:0] i_src_pos_y,
    input  logic signed [31:0] i_src_pos_z,
    input  logic signed [31:0] i_src_vel_x,
    input  logic signed [31:0] i_src_vel_y,
    input  logic signed [31:0] i_src_vel_z,
    input  logic signed [31:0] i_lis_pos_x,
    input  logic signed [31:0] i_lis_pos_y,
    input  logic signed [31:0] i_lis_pos_z,
    input  logic signed [31:0] i_lis_vel_x,
    input  logic signed [31:0] i_lis_vel_y,
    input  logic signed [31:0] i_lis_vel_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_pitch_ratio,
    output logic [2:0]         o_status
);
    import dpr_pkg::*;

    // configuration registers
    logic        r_enable;
    logic [31:0] r_sound_speed;
    logic [23:0] r_velocity_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable        <= RST_ENABLE;
            r_sound_speed   <= RST_SOUND_SPEED;
            r_velocity_gain <= RST_VELOCITY_GAIN;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_ENABLE:        r_enable        <= pwdata[0];
                REG_SOUND_SPEED:   r_sound_speed   <= pwdata;
                REG_VELOCITY_GAIN: r_velocity_gain <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ENABLE:        prdata = {31'd0, r_enable};
            REG_SOUND_SPEED:   prdata = r_sound_speed;
            REG_VELOCITY_GAIN: prdata = {8'd0, r_velocity_gain};
            default:           prdata = 32'd0;
        endcase
    end
    assign pready = 1'b1;

    // the whole pipeline moves unless a finished result is held back
    logic w_adv;
    logic r_o_vld;
    assign w_adv   = !(r_o_vld && i_stall);
    assign o_stall = !w_adv;

    // stage 1: direction from source to listener
    logic               r1_vld;
    logic [2:0]         r1_st;
    logic signed [32:0] r1_d [3];
    logic signed [31:0] r1_vs [3];
    logic signed [31:0] r1_vl [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld   <= i_valid;
            r1_st    <= r_enable ? ST_OK : ST_DISABLED;
            r1_d[0]  <= {i_lis_pos_x[31], i_lis_pos_x} - {i_src_pos_x[31], i_src_pos_x};
            r1_d[1]  <= {i_lis_pos_y[31], i_lis_pos_y} - {i_src_pos_y[31], i_src_pos_y};
            r1_d[2]  <= {i_lis_pos_z[31], i_lis_pos_z} - {i_src_pos_z[31], i_src_pos_z};
            r1_vs[0] <= i_src_vel_x;
            r1_vs[1] <= i_src_vel_y;
            r1_vs[2] <= i_src_vel_z;
            r1_vl[0] <= i_lis_vel_x;
            r1_vl[1] <= i_lis_vel_y;
            r1_vl[2] <= i_lis_vel_z;
        end
    end

    // stage 2: magnitudes, signs and the largest magnitude
    logic               r2_vld;
    logic [2:0]         r2_st;
    logic [32:0]        r2_mag [3];
    logic               r2_neg [3];
    logic [32:0]        r2_m;
    logic signed [31:0] r2_vs [3];
    logic signed [31:0] r2_vl [3];
    logic [32:0]        w2_mag [3];
    logic [32:0]        w2_m;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w2_mag[i] = r1_d[i][32] ? 33'(-r1_d[i]) : 33'(r1_d[i]);
        end
        w2_m = w2_mag[0];
        if (w2_mag[1] > w2_m) w2_m = w2_mag[1];
        if (w2_mag[2] > w2_m) w2_m = w2_mag[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_adv) begin
            r2_vld <= r1_vld;
            r2_st  <= r1_st;
            r2_m   <= w2_m;
            for (int i = 0; i < 3; i++) begin
                r2_mag[i] <= w2_mag[i];
                r2_neg[i] <= r1_d[i][32];
                r2_vs[i]  <= r1_vs[i];
                r2_vl[i]  <= r1_vl[i];
            end
        end
    end

    // stage 3: bit length of the largest magnitude, coincident check
    logic               r3_vld;
    logic [2:0]         r3_st;
    logic [5:0]         r3_b;
    logic [32:0]        r3_mag [3];
    logic               r3_neg [3];
    logic signed [31:0] r3_vs [3];
    logic signed [31:0] r3_vl [3];
    logic [5:0]         w3_b;

    always_comb begin
        w3_b = 6'd0;
        for (int i = 0; i < 33; i++) begin
            if (r2_m[i]) w3_b = 6'(i + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_adv) begin
            r3_vld <= r2_vld;
            r3_st  <= (r2_st == ST_OK && r2_m == 33'd0) ? ST_COINCIDENT : r2_st;
            r3_b   <= w3_b;
            for (int i = 0; i < 3; i++) begin
                r3_mag[i] <= r2_mag[i];
                r3_neg[i] <= r2_neg[i];
                r3_vs[i]  <= r2_vs[i];
                r3_vl[i]  <= r2_vl[i];
            end
        end
    end

    // stage 4: block normalization so the largest lands in [2^20, 2^21)
    logic               r4_vld;
    logic [2:0]         r4_st;
    logic [20:0]        r4_mm [3];
    logic               r4_neg [3];
    logic signed [31:0] r4_vs [3];
    logic signed [31:0] r4_vl [3];
    logic [20:0]        w4_mm [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r3_b > 6'd21) w4_mm[i] = 21'(r3_mag[i] >> (r3_b - 6'd21));
            else              w4_mm[i] = 21'(r3_mag[i] << (6'd21 - r3_b));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_adv) begin
            r4_vld <= r3_vld;
            r4_st  <= r3_st;
            for (int i = 0; i < 3; i++) begin
                r4_mm[i]  <= w4_mm[i];
                r4_neg[i] <= r3_neg[i];
                r4_vs[i]  <= r3_vs[i];
                r4_vl[i]  <= r3_vl[i];
            end
        end
    end

    // stage 5: squares and velocity products
    logic               r5_vld;
    logic [2:0]         r5_st;
    logic [41:0]        r5_sq [3];
    logic signed [53:0] r5_ps [3];
    logic signed [53:0] r5_pl [3];
    logic signed [21:0] w5_dn [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w5_dn[i] = r4_neg[i] ? -$signed({1'b0, r4_mm[i]}) : $signed({1'b0, r4_mm[i]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_adv) begin
            r5_vld <= r4_vld;
            r5_st  <= r4_st;
            for (int i = 0; i < 3; i++) begin
                r5_sq[i] <= r4_mm[i] * r4_mm[i];
                r5_ps[i] <= 54'(r4_vs[i]) * 54'(w5_dn[i]);
                r5_pl[i] <= 54'(r4_vl[i]) * 54'(w5_dn[i]);
            end
        end
    end

    // stage 6: sums, loaded as the token entering the root chain
    t_sqrt_tok r6_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_tok.vld <= 1'b0;
        end else if (w_adv) begin
            r6_tok.vld   <= r5_vld;
            r6_tok.st    <= r5_st;
            r6_tok.rad   <= 44'(r5_sq[0]) + 44'(r5_sq[1]) + 44'(r5_sq[2]);
            r6_tok.rem   <= 24'd0;
            r6_tok.root  <= 22'd0;
            r6_tok.dot_s <= 56'(r5_ps[0]) + 56'(r5_ps[1]) + 56'(r5_ps[2]);
            r6_tok.dot_l <= 56'(r5_pl[0]) + 56'(r5_pl[1]) + 56'(r5_pl[2]);
        end
    end

    // square root chain, one root bit per cell
    t_sqrt_tok w_sq [SQRT_STEPS + 1];
    assign w_sq[0] = r6_tok;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        dpr_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_tok   (w_sq[g]),
            .o_tok   (w_sq[g + 1])
        );
    end

    // stage 7: c*len and the gain products, split at bit 16 of the dot
    t_sqrt_tok          w7_tok;
    logic               r7_vld;
    logic [2:0]         r7_st;
    logic [53:0]        r7_cl;
    logic signed [63:0] r7_ph_s;
    logic signed [63:0] r7_ph_l;
    logic [39:0]        r7_pl_s;
    logic [39:0]        r7_pl_l;
    logic signed [39:0] w7_hi_s;
    logic signed [39:0] w7_hi_l;
    logic signed [64:0] w7_ph_s;
    logic signed [64:0] w7_ph_l;

    assign w7_tok  = w_sq[SQRT_STEPS];
    assign w7_hi_s = 40'(w7_tok.dot_s >>> 16);
    assign w7_hi_l = 40'(w7_tok.dot_l >>> 16);
    assign w7_ph_s = $signed({1'b0, r_velocity_gain}) * w7_hi_s;
    assign w7_ph_l = $signed({1'b0, r_velocity_gain}) * w7_hi_l;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (w_adv) begin
            r7_vld  <= w7_tok.vld;
            r7_st   <= w7_tok.st;
            r7_cl   <= r_sound_speed * w7_tok.root;
            r7_ph_s <= 64'(w7_ph_s);
            r7_ph_l <= 64'(w7_ph_l);
            r7_pl_s <= r_velocity_gain * w7_tok.dot_s[15:0];
            r7_pl_l <= r_velocity_gain * w7_tok.dot_l[15:0];
        end
    end

    // stage 8: floor(s*dot / 2^16) for both velocities
    logic               r8_vld;
    logic [2:0]         r8_st;
    logic [53:0]        r8_cl;
    logic signed [63:0] r8_term_s;
    logic signed [63:0] r8_term_l;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (w_adv) begin
            r8_vld    <= r7_vld;
            r8_st     <= r7_st;
            r8_cl     <= r7_cl;
            r8_term_s <= r7_ph_s + $signed({40'd0, r7_pl_s[39:16]});
            r8_term_l <= r7_ph_l + $signed({40'd0, r7_pl_l[39:16]});
        end
    end

    // stage 9: numerator and denominator
    logic               r9_vld;
    logic [2:0]         r9_st;
    logic signed [63:0] r9_num;
    logic signed [63:0] r9_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else if (w_adv) begin
            r9_vld <= r8_vld;
            r9_st  <= r8_st;
            r9_num <= $signed({10'd0, r8_cl}) - r8_term_l;
            r9_den <= $signed({10'd0, r8_cl}) - r8_term_s;
        end
    end

    // stage 10: magnitudes, sign of the quotient, zero denominator
    logic        r10_vld;
    logic [2:0]  r10_st;
    logic        r10_neg;
    logic [63:0] r10_an;
    logic [63:0] r10_ad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_vld <= 1'b0;
        end else if (w_adv) begin
            r10_vld <= r9_vld;
            r10_st  <= (r9_st == ST_OK && r9_den == 64'sd0) ? ST_ZERO_DEN : r9_st;
            r10_neg <= r9_num[63] ^ r9_den[63];
            r10_an  <= r9_num[63] ? 64'(-r9_num) : 64'(r9_num);
            r10_ad  <= r9_den[63] ? 64'(-r9_den) : 64'(r9_den);
        end
    end

    // stage 11: quotient that needs more than 32 bits saturates, else divide
    t_div_tok r11_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_tok.vld <= 1'b0;
        end else if (w_adv) begin
            r11_tok.vld <= r10_vld;
            r11_tok.st  <= (r10_st == ST_OK && {16'd0, r10_an[63:16]} >= r10_ad)
                           ? ST_SATURATED : r10_st;
            r11_tok.neg <= r10_neg;
            r11_tok.rem <= {16'd0, r10_an[63:16]};
            r11_tok.ad  <= r10_ad;
            r11_tok.lo  <= {r10_an[15:0], 16'd0};
            r11_tok.q   <= 32'd0;
        end
    end

    // divider chain, one quotient bit per cell
    t_div_tok w_dv [DIV_STEPS + 1];
    assign w_dv[0] = r11_tok;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        dpr_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_tok   (w_dv[g]),
            .o_tok   (w_dv[g + 1])
        );
    end

    // output register: final saturation and special case values
    t_div_tok    w_fin;
    logic [31:0] w_limit;
    logic [2:0]  w_st;
    logic [31:0] w_ratio;
    logic [31:0] r_o_ratio;
    logic [2:0]  r_o_st;

    assign w_fin   = w_dv[DIV_STEPS];
    assign w_limit = w_fin.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;

    always_comb begin
        w_st = w_fin.st;
        if (w_st == ST_OK && w_fin.q > w_limit) w_st = ST_SATURATED;
        unique case (w_st)
            ST_OK:         w_ratio = w_fin.neg ? 32'(-w_fin.q) : w_fin.q;
            ST_COINCIDENT: w_ratio = RATIO_ONE;
            ST_SATURATED:  w_ratio = w_limit;
            default:       w_ratio = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_adv) begin
            r_o_vld   <= w_fin.vld;
            r_o_ratio <= w_ratio;
            r_o_st    <= w_st;
        end
    end

    assign o_valid       = r_o_vld;
    assign o_pitch_ratio = r_o_ratio;
    assign o_status      = r_o_st;

    // checks
    a_disabled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_DISABLED) |-> o_pitch_ratio == 32'sd0)
        else $error("disabled result with nonzero ratio");

    a_coincident_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_COINCIDENT) |-> o_pitch_ratio == RATIO_ONE)
        else $error("coincident result not unity");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_SATURATED) |->
        (o_pitch_ratio == 32'h7FFF_FFFF || o_pitch_ratio == 32'h8000_0000))
        else $error("saturated result not at a limit");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_SATURATED)
        else $error("status code out of range");

    a_held_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("pipeline moved while result held");

endmodule
